// File: sv/jcf_pkg.sv
// shared types, constants and constant functions of the johnson-cook flow stress pipeline
`default_nettype none
package jcf_pkg;

    typedef logic signed [63:0] jcf_val_t;
    typedef logic signed [39:0] jcf_log_t;

    typedef enum logic [3:0] {
        REG_BASE_YIELD         = 4'd0,
        REG_HARDENING_MODULUS  = 4'd1,
        REG_RATE_COEFFICIENT   = 4'd2,
        REG_HARDENING_EXPONENT = 4'd3,
        REG_THERMAL_EXPONENT   = 4'd4,
        REG_REFERENCE_RATE     = 4'd5,
        REG_MELT_TEMPERATURE   = 4'd6,
        REG_ROOM_TEMPERATURE   = 4'd7
    } jcf_reg_index_t;

    localparam int LOG_LAT = 32;
    localparam int EXP_LAT = 32;
    localparam int MUL_LAT = 3;

    localparam jcf_val_t SAT_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam jcf_val_t OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam jcf_val_t OUT_MIN = 64'shFFFF_8000_0000_0000;
    localparam jcf_val_t ONE24   = 64'sh0000_0000_0100_0000;
    localparam jcf_val_t ONE28   = 64'sh0000_0000_1000_0000;
    localparam jcf_val_t ONE30   = 64'sh0000_0000_4000_0000;
    localparam jcf_val_t LN2_Q30 = 64'sd744261118;

    function automatic logic [63:0] jcf_isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = 64'd0;
        bit_v = 64'h4000_0000_0000_0000;
        rem   = v;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // root of step i is 2^(2^-i) in q.30, each taken from the one before
    function automatic logic [31:0] jcf_root(input int i);
        logic [63:0] r;
        r = 64'h0000_0000_8000_0000;
        for (int j = 1; j <= i; j++) begin
            r = jcf_isqrt(r << 30);
        end
        return r[31:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/jcf_delay.sv
// fixed-length delay line with hold, used for side data travelling beside the units
`default_nettype none
module jcf_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);
    logic [W-1:0] stage_reg [0:N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) stage_reg[i] <= '0;
        end else if (en) begin
            stage_reg[0] <= d;
            for (int i = 1; i < N; i++) stage_reg[i] <= stage_reg[i-1];
        end
    end

    assign q = stage_reg[N-1];
endmodule
`default_nettype wire

// File: sv/jcf_smul.sv
// pipelined signed multiply with right shift, truncation toward zero and saturation
`default_nettype none
module jcf_smul
    import jcf_pkg::*;
#(
    parameter int SH = 24
) (
    input  wire logic     aclk,
    input  wire logic     en,
    input  wire jcf_val_t a,
    input  wire jcf_val_t b,
    output jcf_val_t      p,
    output logic          ov
);
    logic [63:0]  ma, mb;
    logic         neg1_reg, neg2_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum_reg;
    logic [127:0] sum_next;
    logic [127:0] shifted;
    logic [63:0]  r;
    logic         ov_next;
    jcf_val_t     p_reg;
    logic         ov_reg;

    assign ma = a[63] ? 64'(-a) : 64'(a);
    assign mb = b[63] ? 64'(-b) : 64'(b);

    assign sum_next = {64'd0, p00_reg} + ({64'd0, p01_reg} << 32) + ({64'd0, p10_reg} << 32)
                    + {p11_reg, 64'd0};

    always_comb begin
        shifted = sum_reg >> SH;
        r       = shifted[63:0];
        ov_next = (sum_reg >> (64 + SH)) != 128'd0;
        if (ov_next || r > 64'(SAT_MAX)) begin
            ov_next = 1'b1;
            r       = 64'(SAT_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= a[63] ^ b[63];
            p00_reg  <= 64'(ma[31:0])  * 64'(mb[31:0]);
            p01_reg  <= 64'(ma[31:0])  * 64'(mb[63:32]);
            p10_reg  <= 64'(ma[63:32]) * 64'(mb[31:0]);
            p11_reg  <= 64'(ma[63:32]) * 64'(mb[63:32]);
            neg2_reg <= neg1_reg;
            sum_reg  <= sum_next;
            p_reg    <= neg2_reg ? -jcf_val_t'(r) : jcf_val_t'(r);
            ov_reg   <= ov_next;
        end
    end

    assign p  = p_reg;
    assign ov = ov_reg;
endmodule
`default_nettype wire

// File: sv/jcf_log2.sv
// pipelined base-2 logarithm, q.30 result, one squaring step per stage
`default_nettype none
module jcf_log2
    import jcf_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] x,
    output jcf_log_t         y
);
    logic [63:0] x_reg;
    logic [5:0]  lead_reg;
    logic [5:0]  lead;
    logic [63:0] norm;
    logic [30:0] mt_reg   [0:30];
    logic [29:0] frac_reg [0:30];
    logic [5:0]  p_reg    [0:30];
    logic signed [9:0] expo;

    always_comb begin
        lead = 6'd0;
        for (int i = 1; i < 64; i++) begin
            if (x[i]) lead = 6'(i);
        end
    end

    assign norm = (lead_reg > 6'd30) ? (x_reg >> (lead_reg - 6'd30))
                                     : (x_reg << (6'd30 - lead_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg       <= x;
            lead_reg    <= lead;
            mt_reg[0]   <= norm[30:0];
            frac_reg[0] <= 30'd0;
            p_reg[0]    <= lead_reg;
        end
    end

    for (genvar i = 1; i <= 30; i++) begin : g_sq
        logic [61:0] sq;
        assign sq = 62'(mt_reg[i-1]) * 62'(mt_reg[i-1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[i] <= p_reg[i-1];
                if (sq[61]) begin
                    mt_reg[i]   <= sq[61:31];
                    frac_reg[i] <= frac_reg[i-1] | (30'd1 << (30 - i));
                end else begin
                    mt_reg[i]   <= sq[60:30];
                    frac_reg[i] <= frac_reg[i-1];
                end
            end
        end
    end

    assign expo = $signed({4'd0, p_reg[30]}) - 10'(FRAC_BITS);
    assign y    = {expo, frac_reg[30]};
endmodule
`default_nettype wire

// File: sv/jcf_exp2.sv
// pipelined base-2 exponential, q.30 in, q.24 out, one root product per stage
`default_nettype none
module jcf_exp2
    import jcf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     en,
    input  wire jcf_val_t y,
    output jcf_val_t      z,
    output logic          ov
);
    localparam jcf_val_t Y_HI = 64'sh0000_0010_0000_0000;
    localparam jcf_val_t Y_LO = -64'sh0000_0010_0000_0000;

    logic [31:0]       acc_reg  [0:30];
    logic [29:0]       r_reg    [0:30];
    logic signed [7:0] k_reg    [0:30];
    logic              big_reg  [0:30];
    logic              tiny_reg [0:30];
    jcf_val_t          y_k;
    logic signed [8:0] s;
    logic [63:0]       v;
    jcf_val_t          z_next;
    logic              ov_next;
    jcf_val_t          z_reg;
    logic              ov_reg;

    assign y_k = y >>> 30;

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg[0]  <= 32'h4000_0000;
            r_reg[0]    <= y[29:0];
            k_reg[0]    <= y_k[7:0];
            big_reg[0]  <= y > Y_HI;
            tiny_reg[0] <= y < Y_LO;
        end
    end

    for (genvar i = 1; i <= 30; i++) begin : g_root
        localparam logic [31:0] ROOT = jcf_root(i);
        logic [63:0] prod;
        assign prod = 64'(acc_reg[i-1]) * 64'(ROOT);
        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[i]  <= r_reg[i-1][30-i] ? prod[61:30] : acc_reg[i-1];
                r_reg[i]    <= r_reg[i-1];
                k_reg[i]    <= k_reg[i-1];
                big_reg[i]  <= big_reg[i-1];
                tiny_reg[i] <= tiny_reg[i-1];
            end
        end
    end

    always_comb begin
        s       = 9'(k_reg[30]) - 9'sd6;
        v       = 64'd0;
        z_next  = '0;
        ov_next = 1'b0;
        if (big_reg[30]) begin
            z_next  = SAT_MAX;
            ov_next = 1'b1;
        end else if (tiny_reg[30]) begin
            z_next = '0;
        end else if (s >= 0) begin
            if (s >= 9'sd32) begin
                z_next  = SAT_MAX;
                ov_next = 1'b1;
            end else begin
                v = 64'(acc_reg[30]) << s[4:0];
                if (v > 64'(SAT_MAX)) begin
                    z_next  = SAT_MAX;
                    ov_next = 1'b1;
                end else begin
                    z_next = jcf_val_t'(v);
                end
            end
        end else if (-s >= 9'sd63) begin
            z_next = '0;
        end else begin
            z_next = jcf_val_t'(64'(acc_reg[30]) >> 6'(-s));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg  <= z_next;
            ov_reg <= ov_next;
        end
    end

    assign z  = z_reg;
    assign ov = ov_reg;
endmodule
`default_nettype wire

// File: sv/johnson_cook_flow_stress_top.sv
// johnson-cook flow stress pipeline: top level with configuration registers and stage control
// Johnson-Cook flow stress and its three partial derivatives, one integration point per
// clock. A request on the s_ channel enters a fixed pipeline and its result leaves on the m_
// channel; the depth is set by two log2 passes (30 squaring stages each), two exp2 passes
// (30 root-product stages each) and the 64 by 64 bit multipliers. The whole pipeline holds
// while a finished result is not taken. Configuration writes are taken at any time but must
// only be made while no request is in flight.
`default_nettype none
module johnson_cook_flow_stress_top
    import jcf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [47:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_plastic_strain,
    input  wire logic [47:0] s_strain_rate,
    input  wire logic [31:0] s_temperature,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [47:0]      m_flow_stress,
    output logic [47:0]      m_slope_strain,
    output logic [47:0]      m_slope_rate,
    output logic [47:0]      m_slope_temperature,
    output logic             m_saturated
);
    typedef struct packed {
        logic valid;
        logic clip;
        logic eps0;
        logic fast;
        logic twin;
        logic thot;
    } ctl_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] eps;
        logic [47:0] rate;
        logic [31:0] dtemp;
    } s0_t;

    typedef struct packed {
        ctl_t     ctl;
        jcf_log_t lr;
        jcf_log_t ldt;
    } b_t;

    typedef struct packed {
        ctl_t     ctl;
        jcf_log_t lr;
        logic     c_x1;
        logic     c_x2;
        logic     c_lnq;
        logic     c_mth;
    } c_t;

    typedef struct packed {
        ctl_t     ctl;
        jcf_log_t lr;
        jcf_val_t hsum;
        jcf_val_t vfac;
        jcf_val_t dv;
        jcf_val_t tfac;
        jcf_val_t gfac;
    } d_t;

    typedef struct packed {
        ctl_t     ctl;
        jcf_log_t lr;
        jcf_val_t tfac;
        jcf_val_t gfac;
        logic     rsel;
        logic     rneg;
    } e_t;

    typedef struct packed {
        ctl_t     ctl;
        jcf_val_t tfac;
        jcf_val_t gfac;
        logic     rsel;
        logic     rneg;
        jcf_val_t hv;
        jcf_val_t sdv;
    } f_t;

    typedef struct packed {
        jcf_val_t hv;
        jcf_val_t sdv;
        logic     c_hv;
        logic     c_sdv;
    } hvd_t;

    function automatic logic [64:0] sat_add(jcf_val_t a, jcf_val_t b);
        jcf_val_t s;
        s = a + b;
        if (s > SAT_MAX) return {1'b1, SAT_MAX};
        if (s < -SAT_MAX) return {1'b1, -SAT_MAX};
        return {1'b0, s};
    endfunction

    function automatic logic [48:0] to_out(jcf_val_t v);
        jcf_val_t q;
        q = v[63] ? -((-v) >>> 8) : (v >>> 8);
        if (q > OUT_MAX) return {1'b1, OUT_MAX[47:0]};
        if (q < OUT_MIN) return {1'b1, OUT_MIN[47:0]};
        return {1'b0, q[47:0]};
    endfunction

    // configuration registers
    logic [47:0] a_reg, b_reg, r0_reg;
    logic [31:0] c_reg, n_reg, m_reg, tm_reg, t0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg  <= '0;
            b_reg  <= '0;
            c_reg  <= '0;
            n_reg  <= 32'h1000_0000;
            m_reg  <= 32'h1000_0000;
            r0_reg <= 48'h0000_0001_0000;
            tm_reg <= '0;
            t0_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BASE_YIELD:         a_reg  <= cfg_wdata;
                REG_HARDENING_MODULUS:  b_reg  <= cfg_wdata;
                REG_RATE_COEFFICIENT:   c_reg  <= cfg_wdata[31:0];
                REG_HARDENING_EXPONENT: n_reg  <= cfg_wdata[31:0];
                REG_THERMAL_EXPONENT:   m_reg  <= cfg_wdata[31:0];
                REG_REFERENCE_RATE:     r0_reg <= cfg_wdata;
                REG_MELT_TEMPERATURE:   tm_reg <= cfg_wdata[31:0];
                REG_ROOM_TEMPERATURE:   t0_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    logic [47:0] r0_eff, bmag;
    logic [31:0] cmag;
    jcf_val_t    av, nv, mv, cv, bmag256;

    assign r0_eff  = (r0_reg == 48'd0) ? 48'd1 : r0_reg;
    assign bmag    = b_reg[47] ? 48'(-$signed(b_reg)) : b_reg;
    assign cmag    = c_reg[31] ? 32'(-$signed(c_reg)) : c_reg;
    assign av      = jcf_val_t'($signed(a_reg)) <<< 8;
    assign nv      = jcf_val_t'({32'd0, n_reg});
    assign mv      = jcf_val_t'({32'd0, m_reg});
    assign cv      = jcf_val_t'($signed(c_reg));
    assign bmag256 = jcf_val_t'({8'd0, bmag, 8'd0});

    // logarithms of configuration values, free running
    jcf_log_t lb, ln_n, ln_m, lr0, ltm, lc;

    jcf_log2 #(.FRAC_BITS(16)) u_log_b (.aclk, .en(1'b1), .x(64'(bmag)), .y(lb));
    jcf_log2 #(.FRAC_BITS(28)) u_log_n (.aclk, .en(1'b1), .x(64'(n_reg)), .y(ln_n));
    jcf_log2 #(.FRAC_BITS(28)) u_log_m (.aclk, .en(1'b1), .x(64'(m_reg)), .y(ln_m));
    jcf_log2 #(.FRAC_BITS(16)) u_log_r0 (.aclk, .en(1'b1), .x(64'(r0_eff)), .y(lr0));
    jcf_log2 #(.FRAC_BITS(16)) u_log_tm (.aclk, .en(1'b1), .x(64'(tm_reg - t0_reg)), .y(ltm));
    jcf_log2 #(.FRAC_BITS(28)) u_log_c (.aclk, .en(1'b1), .x(64'(cmag)), .y(lc));

    // stage control
    logic m_valid_reg;
    logic adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // input stage
    s0_t s0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg <= '0;
        end else if (adv) begin
            s0_reg.ctl.valid <= s_valid;
            s0_reg.ctl.clip  <= 1'b0;
            s0_reg.ctl.eps0  <= s_plastic_strain == 32'd0;
            s0_reg.ctl.fast  <= s_strain_rate > r0_eff;
            s0_reg.ctl.twin  <= (s_temperature > t0_reg) && (s_temperature < tm_reg);
            s0_reg.ctl.thot  <= (s_temperature > t0_reg) && !(s_temperature < tm_reg);
            s0_reg.eps       <= s_plastic_strain;
            s0_reg.rate      <= s_strain_rate;
            s0_reg.dtemp     <= s_temperature - t0_reg;
        end
    end

    // logs of the point
    jcf_log_t le, lr, ldt;
    ctl_t     ctl_a;

    jcf_log2 #(.FRAC_BITS(24)) u_log_e (.aclk, .en(adv), .x(64'(s0_reg.eps)), .y(le));
    jcf_log2 #(.FRAC_BITS(16)) u_log_r (.aclk, .en(adv), .x(64'(s0_reg.rate)), .y(lr));
    jcf_log2 #(.FRAC_BITS(16)) u_log_t (.aclk, .en(adv), .x(64'(s0_reg.dtemp)), .y(ldt));
    jcf_delay #(.W($bits(ctl_t)), .N(LOG_LAT)) u_dly_a (
        .aclk, .aresetn, .en(adv), .d(s0_reg.ctl), .q(ctl_a)
    );

    // exponent products
    jcf_val_t x1, x2, lnq, mth;
    logic     c_x1, c_x2, c_lnq, c_mth;
    b_t       sb;

    jcf_smul #(.SH(28)) u_mul_x1 (.aclk, .en(adv), .a(nv), .b(jcf_val_t'(le)), .p(x1), .ov(c_x1));
    jcf_smul #(.SH(28)) u_mul_x2 (
        .aclk, .en(adv), .a(nv - ONE28), .b(jcf_val_t'(le)), .p(x2), .ov(c_x2)
    );
    jcf_smul #(.SH(30)) u_mul_lnq (
        .aclk, .en(adv), .a(jcf_val_t'(lr) - jcf_val_t'(lr0)), .b(LN2_Q30), .p(lnq), .ov(c_lnq)
    );
    jcf_smul #(.SH(28)) u_mul_mth (
        .aclk, .en(adv), .a(mv), .b(jcf_val_t'(ldt) - jcf_val_t'(ltm)), .p(mth), .ov(c_mth)
    );
    jcf_delay #(.W($bits(b_t)), .N(MUL_LAT)) u_dly_b (
        .aclk, .aresetn, .en(adv), .d({ctl_a, lr, ldt}), .q(sb)
    );

    // exponentials and rate factor product
    jcf_val_t pw_e, dv_e, th_e, g_e, cm, cm_raw;
    logic     c_pw, c_dv, c_th, c_g, c_cm, c_cm_raw;
    c_t       sc;

    jcf_exp2 u_exp_pw (
        .aclk, .en(adv), .y(jcf_val_t'(lb) + x1), .z(pw_e), .ov(c_pw)
    );
    jcf_exp2 u_exp_dv (
        .aclk, .en(adv), .y(jcf_val_t'(ln_n) + jcf_val_t'(lb) + x2), .z(dv_e), .ov(c_dv)
    );
    jcf_exp2 u_exp_th (.aclk, .en(adv), .y(mth), .z(th_e), .ov(c_th));
    jcf_exp2 u_exp_g (
        .aclk, .en(adv), .y(jcf_val_t'(ln_m) + mth - jcf_val_t'(sb.ldt)), .z(g_e), .ov(c_g)
    );
    jcf_smul #(.SH(34)) u_mul_cm (.aclk, .en(adv), .a(cv), .b(lnq), .p(cm_raw), .ov(c_cm_raw));
    jcf_delay #(.W(65), .N(EXP_LAT - MUL_LAT)) u_dly_cm (
        .aclk, .aresetn, .en(adv), .d({c_cm_raw, cm_raw}), .q({c_cm, cm})
    );
    jcf_delay #(.W($bits(c_t)), .N(EXP_LAT)) u_dly_c (
        .aclk, .aresetn, .en(adv), .d({sb.ctl, sb.lr, c_x1, c_x2, c_lnq, c_mth}), .q(sc)
    );

    // factor assembly
    d_t          d_reg;
    d_t          d_next;
    logic [64:0] hs_add, vf_add;
    jcf_val_t    pw, dv;
    logic        b_nz, n_nz;

    assign b_nz = bmag != 48'd0;
    assign n_nz = n_reg != 32'd0;

    always_comb begin
        pw = '0;
        if (b_nz) begin
            if (sc.ctl.eps0) pw = n_nz ? jcf_val_t'(0) : bmag256;
            else             pw = pw_e;
            if (b_reg[47]) pw = -pw;
        end
        dv = '0;
        if (b_nz && n_nz) begin
            if (sc.ctl.eps0) begin
                if (nv < ONE28)       dv = SAT_MAX;
                else if (nv == ONE28) dv = bmag256;
                else                  dv = '0;
            end else begin
                dv = dv_e;
            end
            if (b_reg[47]) dv = -dv;
        end
        hs_add = sat_add(av, pw);
        vf_add = sat_add(ONE24, cm);

        d_next          = '0;
        d_next.ctl      = sc.ctl;
        d_next.lr       = sc.lr;
        d_next.hsum     = hs_add[63:0];
        d_next.vfac     = sc.ctl.fast ? jcf_val_t'(vf_add[63:0]) : ONE24;
        d_next.dv       = dv;
        d_next.tfac     = sc.ctl.twin ? ONE24 - th_e : (sc.ctl.thot ? jcf_val_t'(0) : ONE24);
        d_next.gfac     = (sc.ctl.twin && m_reg != 32'd0) ? -g_e : jcf_val_t'(0);
        d_next.ctl.clip = sc.ctl.clip | hs_add[64]
                        | (b_nz && !sc.ctl.eps0 && (sc.c_x1 || c_pw))
                        | (b_nz && n_nz && (sc.ctl.eps0 ? (nv < ONE28) : (sc.c_x2 || c_dv)))
                        | (sc.ctl.fast && (sc.c_lnq || c_cm || vf_add[64]))
                        | (sc.ctl.twin && (sc.c_mth || c_th || (m_reg != 32'd0 && c_g)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg <= '0;
        end else if (adv) begin
            d_reg <= d_next;
        end
    end

    // rate term log and stress products
    jcf_log_t lh;
    jcf_val_t hv_raw, sdv_raw;
    logic     c_hv_raw, c_sdv_raw;
    hvd_t     hvd;
    e_t       se;
    e_t       e_in;

    always_comb begin
        e_in      = '0;
        e_in.ctl  = d_reg.ctl;
        e_in.lr   = d_reg.lr;
        e_in.tfac = d_reg.tfac;
        e_in.gfac = d_reg.gfac;
        e_in.rsel = d_reg.ctl.fast && cv != 0 && d_reg.hsum != 0;
        e_in.rneg = d_reg.hsum[63] ^ cv[63];
    end

    jcf_log2 #(.FRAC_BITS(24)) u_log_h (
        .aclk, .en(adv), .x(d_reg.hsum[63] ? 64'(-d_reg.hsum) : 64'(d_reg.hsum)), .y(lh)
    );
    jcf_smul #(.SH(24)) u_mul_hv (
        .aclk, .en(adv), .a(d_reg.hsum), .b(d_reg.vfac), .p(hv_raw), .ov(c_hv_raw)
    );
    jcf_smul #(.SH(24)) u_mul_sdv (
        .aclk, .en(adv), .a(d_reg.dv), .b(d_reg.vfac), .p(sdv_raw), .ov(c_sdv_raw)
    );
    jcf_delay #(.W($bits(hvd_t)), .N(LOG_LAT - MUL_LAT)) u_dly_hv (
        .aclk, .aresetn, .en(adv), .d({hv_raw, sdv_raw, c_hv_raw, c_sdv_raw}), .q(hvd)
    );
    jcf_delay #(.W($bits(e_t)), .N(LOG_LAT)) u_dly_e (
        .aclk, .aresetn, .en(adv), .d(e_in), .q(se)
    );

    // rate term exponential
    jcf_val_t r_e;
    logic     c_r;
    f_t       sf;
    f_t       f_in;

    always_comb begin
        f_in          = '0;
        f_in.ctl      = se.ctl;
        f_in.ctl.clip = se.ctl.clip | hvd.c_hv | hvd.c_sdv;
        f_in.tfac     = se.tfac;
        f_in.gfac     = se.gfac;
        f_in.rsel     = se.rsel;
        f_in.rneg     = se.rneg;
        f_in.hv       = hvd.hv;
        f_in.sdv      = hvd.sdv;
    end

    jcf_exp2 u_exp_r (
        .aclk, .en(adv), .y(jcf_val_t'(lh) + jcf_val_t'(lc) - jcf_val_t'(se.lr)),
        .z(r_e), .ov(c_r)
    );
    jcf_delay #(.W($bits(f_t)), .N(EXP_LAT)) u_dly_f (
        .aclk, .aresetn, .en(adv), .d(f_in), .q(sf)
    );

    // output products
    jcf_val_t rterm;
    jcf_val_t o0, o1, o2, o3;
    logic     c_o0, c_o1, c_o2, c_o3;
    ctl_t     g_in;
    ctl_t     sg;

    assign rterm = sf.rsel ? (sf.rneg ? -r_e : r_e) : jcf_val_t'(0);

    always_comb begin
        g_in      = sf.ctl;
        g_in.clip = sf.ctl.clip | (sf.rsel && c_r);
    end

    jcf_smul #(.SH(24)) u_mul_o0 (.aclk, .en(adv), .a(sf.hv), .b(sf.tfac), .p(o0), .ov(c_o0));
    jcf_smul #(.SH(24)) u_mul_o1 (.aclk, .en(adv), .a(sf.sdv), .b(sf.tfac), .p(o1), .ov(c_o1));
    jcf_smul #(.SH(24)) u_mul_o2 (.aclk, .en(adv), .a(rterm), .b(sf.tfac), .p(o2), .ov(c_o2));
    jcf_smul #(.SH(24)) u_mul_o3 (.aclk, .en(adv), .a(sf.hv), .b(sf.gfac), .p(o3), .ov(c_o3));
    jcf_delay #(.W($bits(ctl_t)), .N(MUL_LAT)) u_dly_g (
        .aclk, .aresetn, .en(adv), .d(g_in), .q(sg)
    );

    // output register
    logic [48:0] q0, q1, q2, q3;
    logic [47:0] flow_reg, slope_strain_reg, slope_rate_reg, slope_temp_reg;
    logic        sat_reg;

    assign q0 = to_out(o0);
    assign q1 = to_out(o1);
    assign q2 = to_out(sg.fast ? o2 : jcf_val_t'(0));
    assign q3 = to_out(o3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= sg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            flow_reg         <= q0[47:0];
            slope_strain_reg <= q1[47:0];
            slope_rate_reg   <= q2[47:0];
            slope_temp_reg   <= q3[47:0];
            sat_reg          <= sg.clip | c_o0 | c_o1 | (sg.fast && c_o2) | c_o3
                              | q0[48] | q1[48] | q2[48] | q3[48];
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_flow_stress       = flow_reg;
    assign m_slope_strain      = slope_strain_reg;
    assign m_slope_rate        = slope_rate_reg;
    assign m_slope_temperature = slope_temp_reg;
    assign m_saturated         = sat_reg;
endmodule
`default_nettype wire

// File: sv/jcf_checker.sv
// port-level checker for the flow stress pipeline and its bind to the top level
`default_nettype none
module jcf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic [3:0]  cfg_index,
    input wire logic [47:0] cfg_wdata,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [31:0] s_plastic_strain,
    input wire logic [47:0] s_strain_rate,
    input wire logic [31:0] s_temperature,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [47:0] m_flow_stress,
    input wire logic [47:0] m_slope_strain,
    input wire logic [47:0] m_slope_rate,
    input wire logic [47:0] m_slope_temperature,
    input wire logic        m_saturated
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flow_stress) && $stable(m_slope_strain)
            && $stable(m_slope_rate) && $stable(m_slope_temperature) && $stable(m_saturated))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output stage never blocks a request
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request blocked with empty output");

    // a taken result frees the input side in the same cycle
    a_ready_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("request blocked while result taken");
endmodule

bind johnson_cook_flow_stress_top jcf_checker u_jcf_checker (.*);
`default_nettype wire

// File: sim/johnson_cook_flow_stress_top_tb.sv
// testbench for the johnson-cook flow stress pipeline: bit-exact prediction and streaming checks
`timescale 1ns / 100ps
`default_nettype none
module johnson_cook_flow_stress_top_tb
    import jcf_pkg::*;
;

    localparam int    PIPE_DEPTH = 137;
    localparam int    HANG_LIMIT = 20000;
    localparam int    MAX_SHOWN  = 10;
    localparam [3:0]  REG_UNUSED = 4'd9;

    typedef struct packed {
        logic [47:0] flow_stress;
        logic [47:0] slope_strain;
        logic [47:0] slope_rate;
        logic [47:0] slope_temperature;
        logic        saturated;
    } stress_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [47:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_plastic_strain = '0;
    logic [47:0] s_strain_rate = '0;
    logic [31:0] s_temperature = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_flow_stress, m_slope_strain, m_slope_rate, m_slope_temperature;
    logic        m_saturated;

    johnson_cook_flow_stress_top dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // model copy of the registers
    bit signed [47:0] yield_a = 0, modulus_b = 0;
    bit signed [31:0] rate_c = 0;
    bit [31:0] exp_n = 32'd268435456, exp_m = 32'd268435456;
    bit [47:0] rate_ref = 48'd65536;
    bit [31:0] t_melt = 0, t_room = 0;
    bit        clipped;

    stress_result_t pending_stress[$];
    int  mismatches = 0;
    bit  hung = 1'b0;
    int  send_idle_pct = 0, recv_stall_pct = 0;

    function automatic bit [63:0] magn(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint fx_mul(longint a, longint b, int sh);
        bit [127:0] p;
        bit [63:0]  r;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        p = p >> sh;
        r = p[63:0];
        if (p[127:64] != 0 || r > 64'(SAT_MAX)) begin
            clipped = 1'b1;
            r = 64'(SAT_MAX);
        end
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SAT_MAX) begin
            clipped = 1'b1;
            return SAT_MAX;
        end
        if (s < -SAT_MAX) begin
            clipped = 1'b1;
            return -SAT_MAX;
        end
        return s;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint log2_fx(bit [63:0] x, int f);
        int p;
        bit [63:0] mt;
        longint frac;
        p = 63;
        frac = 0;
        while (p > 0 && !x[p]) p--;
        mt = p > 30 ? x >> (p - 30) : x << (30 - p);
        for (int i = 1; i <= 30; i++) begin
            mt = (mt * mt) >> 30;
            if (mt >= (64'd1 << 31)) begin
                mt >>= 1;
                frac |= longint'(1) << (30 - i);
            end
        end
        return longint'(p - f) * ONE30 + frac;
    endfunction

    function automatic longint exp2_fx(longint y);
        longint k, r, s;
        bit [63:0] acc, root, v;
        acc = 64'(ONE30);
        root = 64'd1 << 31;
        if (y > 64 * ONE30) begin
            clipped = 1'b1;
            return SAT_MAX;
        end
        if (y < -64 * ONE30) return 0;
        k = y >= 0 ? y / ONE30 : -((-y + ONE30 - 1) / ONE30);
        r = y - k * ONE30;
        for (int i = 1; i <= 30; i++) begin
            root = int_sqrt(root << 30);
            if (r[30 - i]) acc = (acc * root) >> 30;
        end
        s = k - 6;
        if (s >= 0) begin
            if (s >= 32) begin
                clipped = 1'b1;
                return SAT_MAX;
            end
            v = acc << s;
            if (v > 64'(SAT_MAX)) begin
                clipped = 1'b1;
                return SAT_MAX;
            end
            return longint'(v);
        end
        if (-s >= 63) return 0;
        return longint'(acc >> (-s));
    endfunction

    function automatic logic [47:0] to_q16(longint v);
        longint q;
        q = v / 256;
        if (q > OUT_MAX) begin
            clipped = 1'b1;
            q = OUT_MAX;
        end
        if (q < OUT_MIN) begin
            clipped = 1'b1;
            q = OUT_MIN;
        end
        return q[47:0];
    endfunction

    function automatic stress_result_t flow_stress_of(bit [31:0] eps, bit [47:0] rate,
                                                      bit [31:0] temp);
        stress_result_t res;
        longint av, bv, cv, nv, mv, le, lb, pw, dv, hsum, vfac, rterm, tfac, gfac, hv;
        longint lrate, lnq, ldt, mth;
        bit [63:0] bmag, r0;
        bit fast;
        av = longint'(yield_a) * 256;
        bv = longint'(modulus_b);
        cv = longint'(rate_c);
        nv = longint'(exp_n);
        mv = longint'(exp_m);
        r0 = rate_ref != 0 ? 64'(rate_ref) : 64'd1;
        bmag = magn(bv);
        le = 0; lb = 0; pw = 0; dv = 0; vfac = ONE24; rterm = 0; tfac = ONE24; gfac = 0;
        fast = 64'(rate) > r0;
        clipped = 1'b0;
        if (eps != 0) le = log2_fx(64'(eps), 24);
        if (bmag != 0) begin
            lb = log2_fx(bmag, 16);
            if (eps == 0) pw = nv == 0 ? longint'(bmag * 256) : 0;
            else pw = exp2_fx(lb + fx_mul(nv, le, 28));
            if (bv < 0) pw = -pw;
        end
        hsum = fx_add(av, pw);
        if (bmag != 0 && nv != 0) begin
            if (eps == 0) begin
                if (nv < ONE28) begin
                    dv = SAT_MAX;
                    clipped = 1'b1;
                end else if (nv == ONE28) begin
                    dv = longint'(bmag * 256);
                end else begin
                    dv = 0;
                end
            end else begin
                dv = exp2_fx(log2_fx(64'(nv), 28) + lb + fx_mul(nv - ONE28, le, 28));
            end
            if (bv < 0) dv = -dv;
        end
        if (fast) begin
            lrate = log2_fx(64'(rate), 16);
            lnq = fx_mul(lrate - log2_fx(r0, 16), LN2_Q30, 30);
            vfac = fx_add(ONE24, fx_mul(cv, lnq, 34));
            if (cv != 0 && hsum != 0) begin
                rterm = exp2_fx(log2_fx(magn(hsum), 24) + log2_fx(magn(cv), 28) - lrate);
                if ((hsum < 0) != (cv < 0)) rterm = -rterm;
            end
        end
        if (temp > t_room) begin
            if (temp < t_melt) begin
                ldt = log2_fx(64'(temp - t_room), 16);
                mth = fx_mul(mv, ldt - log2_fx(64'(t_melt - t_room), 16), 28);
                tfac = ONE24 - exp2_fx(mth);
                if (mv != 0) gfac = -exp2_fx(log2_fx(64'(mv), 28) + mth - ldt);
            end else begin
                tfac = 0;
            end
        end
        hv = fx_mul(hsum, vfac, 24);
        res.flow_stress = to_q16(fx_mul(hv, tfac, 24));
        res.slope_strain = to_q16(fx_mul(fx_mul(dv, vfac, 24), tfac, 24));
        res.slope_rate = to_q16(fast ? fx_mul(rterm, tfac, 24) : 0);
        res.slope_temperature = to_q16(fx_mul(hv, gfac, 24));
        res.saturated = clipped;
        return res;
    endfunction

    task automatic write_reg(logic [3:0] idx, logic [47:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_BASE_YIELD:         yield_a = val;
            REG_HARDENING_MODULUS:  modulus_b = val;
            REG_RATE_COEFFICIENT:   rate_c = val[31:0];
            REG_HARDENING_EXPONENT: exp_n = val[31:0];
            REG_THERMAL_EXPONENT:   exp_m = val[31:0];
            REG_REFERENCE_RATE:     rate_ref = val;
            REG_MELT_TEMPERATURE:   t_melt = val[31:0];
            REG_ROOM_TEMPERATURE:   t_room = val[31:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_stress.size() != 0 && !hung) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
    endtask

    task automatic load_material(logic [47:0] a, logic [47:0] b, logic [31:0] c,
                                 logic [31:0] n, logic [31:0] m, logic [47:0] r0,
                                 logic [31:0] tm, logic [31:0] t0);
        drain_pipeline();
        write_reg(REG_BASE_YIELD, a);
        write_reg(REG_HARDENING_MODULUS, b);
        write_reg(REG_RATE_COEFFICIENT, {16'd0, c});
        write_reg(REG_HARDENING_EXPONENT, {16'd0, n});
        write_reg(REG_THERMAL_EXPONENT, {16'd0, m});
        write_reg(REG_REFERENCE_RATE, r0);
        write_reg(REG_MELT_TEMPERATURE, {16'd0, tm});
        write_reg(REG_ROOM_TEMPERATURE, {16'd0, t0});
    endtask

    task automatic send_point(logic [31:0] eps, logic [47:0] rate, logic [31:0] temp);
        bit rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_plastic_strain <= eps;
        s_strain_rate <= rate;
        s_temperature <= temp;
        pending_stress.push_back(flow_stress_of(eps, rate, temp));
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy && !hung);
    endtask

    always @(posedge aclk) m_ready <= $urandom_range(99) >= recv_stall_pct;

    // result checks and hang watchdog, sampled mid-cycle
    int quiet_cycles = 0;
    always @(negedge aclk) begin
        stress_result_t want, got;
        if (aresetn) begin
            quiet_cycles <= (s_valid && s_ready) || (m_valid && m_ready) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) hung <= 1'b1;
            if (m_valid && m_ready) begin
                got = '{m_flow_stress, m_slope_strain, m_slope_rate, m_slope_temperature,
                        m_saturated};
                if (pending_stress.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result %h", got);
                end else begin
                    want = pending_stress.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                                     want.flow_stress, want.slope_strain, want.slope_rate,
                                     want.slope_temperature, want.saturated,
                                     got.flow_stress, got.slope_strain, got.slope_rate,
                                     got.slope_temperature, got.saturated);
                    end
                end
            end
        end
    end

    function automatic logic [47:0] rand48();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_reset_values();
        send_point(32'h0100_0000, 48'h2_0000, 32'd0);
        send_point(32'd0, 48'd0, 32'hFFFF_FFFF);
        send_point(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0001_0000);
    endtask

    task automatic test_special_cases();
        // zero strain with n below, at and above one, and zero n
        load_material(48'd300 << 16, 48'd500 << 16, 32'h0040_0000, 32'h0800_0000,
                      32'h1000_0000, 48'h1_0000, 32'd1700 << 16, 32'd293 << 16);
        send_point(32'd0, 48'h1_0000, 32'd300 << 16);
        drain_pipeline();
        write_reg(REG_HARDENING_EXPONENT, 48'h1000_0000);
        send_point(32'd0, 48'h8_0000, 32'd800 << 16);
        drain_pipeline();
        write_reg(REG_HARDENING_EXPONENT, 48'h2000_0000);
        send_point(32'd0, 48'd5, 32'd1700 << 16);
        drain_pipeline();
        write_reg(REG_HARDENING_EXPONENT, 48'd0);
        send_point(32'd0, 48'h10_0000, 32'd1000 << 16);
        send_point(32'h0080_0000, 48'h10_0000, 32'd1000 << 16);
        // melt not above room, zero thermal exponent, zero b and c, zero reference rate
        load_material(-(48'd100 << 16), -(48'd400 << 16), 32'hFFF0_0000, 32'h0400_0000,
                      32'd0, 48'd0, 32'd200 << 16, 32'd400 << 16);
        send_point(32'h0100_0000, 48'd1, 32'd500 << 16);
        send_point(32'h0100_0000, 48'd2, 32'd100 << 16);
        drain_pipeline();
        write_reg(REG_UNUSED, rand48());
        load_material(48'd0, 48'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                      32'hFFFF_FFFF, 32'd0);
        send_point(32'h0000_0001, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
        // hsum cancels to zero
        load_material(-(48'd1 << 16), 48'd1 << 16, 32'h1000_0000, 32'h1000_0000,
                      32'h1000_0000, 48'h1_0000, 32'd1000 << 16, 32'd0);
        send_point(32'h0100_0000, 48'h4_0000, 32'd500 << 16);
        // register extremes
        load_material(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 48'd1, 32'hFFFF_FFFF, 32'd0);
        send_point(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'd1, 48'd2, 32'd1);
        load_material(48'h8000_0000_0000, 48'h8000_0000_0000, 32'h8000_0000, 32'd1,
                      32'd1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_point(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0000_0100, 48'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_materials(int count);
        logic [31:0] eps, temp, lo_t, hi_t;
        logic [47:0] rate;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            load_material(rand48(), rand48(), $urandom(), $urandom(), $urandom(),
                          rand48() | 48'd1, $urandom(), $urandom());
        end else begin
            lo_t = $urandom_range(400) << 16;
            hi_t = lo_t + ($urandom_range(2000) << 16) + $urandom_range(65535);
            load_material(48'($urandom_range(2000)) << 16 | 48'($urandom_range(65535)),
                          ($urandom_range(1) ? 48'd0 - 48'($urandom_range(1000) << 16) :
                           48'($urandom_range(2000) << 16)) + 48'($urandom_range(65535)),
                          ($urandom_range(1) ? -1 : 1) * $urandom_range(32'h0400_0000),
                          $urandom_range(32'h2000_0000), $urandom_range(32'h3000_0000),
                          48'($urandom_range(32'h0010_0000)) + 48'd1, hi_t, lo_t);
        end
        repeat (count) begin
            if (hung) return;
            pick = $urandom_range(3);
            eps = pick == 0 ? $urandom() : $urandom_range(32'h0400_0000);
            if ($urandom_range(15) == 0) eps = 0;
            rate = pick == 1 ? rand48() : 48'($urandom_range(32'h1000_0000));
            temp = pick == 2 ? $urandom() :
                   t_room - 32'h10_0000 + $urandom_range(t_melt - t_room + 32'h20_0000);
            send_point(eps, rate, temp);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_special_cases();
        for (int ph = 0; ph < 20 && !hung; ph++) begin
            drain_pipeline();
            send_idle_pct  = (ph % 4 == 1) ? 73 : (ph % 4 == 3) ? 35 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 73 : (ph % 4 == 3) ? 35 : 0;
            test_random_materials(86);
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        recv_stall_pct = 0;
        while (pending_stress.size() != 0 && !hung) @(posedge aclk);
        repeat (PIPE_DEPTH + 20) @(posedge aclk);
        if (hung) begin
            $display("*** FAILED ***");
        end else if (mismatches == 0 && pending_stress.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
sv/jcf_pkg.sv
sv/jcf_delay.sv
sv/jcf_smul.sv
sv/jcf_log2.sv
sv/jcf_exp2.sv
sv/johnson_cook_flow_stress_top.sv
sv/jcf_checker.sv
sim/johnson_cook_flow_stress_top_tb.sv
